>>> rtl/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants for the stream pattern replacer
// Payload structs, register indexes, result bundle and length helpers.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int WIN_IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W           = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_FIRST_ONLY         = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_end;
    } out_item_t;

    typedef logic [MAX_PATTERN-1:0][7:0] window_t;

    // Everything one input byte produces, handed from the matcher to the top level.
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] bytes;     // result bytes, first in entry 0
        logic [LEN_W-1:0]            cnt;       // number of result items, 0..8
        logic                        marker;    // single end-only item
        logic                        last;      // final results of the text
        window_t                     win_next;  // pending window after this byte
        logic [WIN_IDX_W-1:0]        pend_next; // pending count after this byte
        logic                        repl_next; // replaced flag after this byte
    } spr_result_t;

    // Pattern length as used: zero acts as one, oversize clamps.
    function automatic logic [LEN_W-1:0] eff_plen(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        n = raw;
        if (n == '0)
        begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_PATTERN))
        begin
            n = LEN_W'(MAX_PATTERN);
        end
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] eff_rlen(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        n = raw;
        if (n > LEN_W'(MAX_REPLACEMENT))
        begin
            n = LEN_W'(MAX_REPLACEMENT);
        end
        return n;
    endfunction

endpackage

>>> rtl/stream_pattern_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_replace: streaming find-and-replace on a byte stream
// Replaces leftmost non-overlapping occurrences of a configured pattern.
// ----------------------------------------------------------------------------
// Usage: text enters one byte per transfer on in_data, text_end marking the
// last byte. Each accepted byte is registered, then matched combinationally
// against the pattern and its results (zero to eight items) land in a
// result buffer that drains one item per cycle on out_data while out_ready
// is high. A new byte can be taken every cycle while out_ready is high; the
// input side only waits when a byte produces more than one result, holding
// the next byte until those results drain (a match with an eight-byte
// replacement, or the flush at end of text). The result buffer's single
// output port is the cause. Bytes that only fill the window produce no
// result. A text whose rewrite is empty yields one end-only item with
// has_byte low. Write the configuration registers only while the block is
// idle; writes to indexes above first_only are ignored.
// ----------------------------------------------------------------------------
module stream_pattern_replace
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  spr_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output spr_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic [spr_pkg::CFG_DATA_W-1:0]  pattern_bytes_reg;
    logic [spr_pkg::LEN_W-1:0]       pattern_length_reg;
    logic [spr_pkg::CFG_DATA_W-1:0]  replacement_bytes_reg;
    logic [spr_pkg::LEN_W-1:0]       replacement_length_reg;
    logic                            first_only_reg;

    // input register
    logic                            in_valid_reg;
    spr_pkg::in_item_t               in_item_reg;

    // match state
    spr_pkg::window_t                win_reg;
    spr_pkg::window_t                win_next;
    logic [spr_pkg::WIN_IDX_W-1:0]   pend_reg;
    logic [spr_pkg::WIN_IDX_W-1:0]   pend_next;
    logic                            repl_reg;
    logic                            repl_next;

    // result buffer, entry 0 is on the output
    logic [spr_pkg::MAX_PATTERN-1:0][7:0] res_bytes_reg;
    logic [spr_pkg::MAX_PATTERN-1:0][7:0] res_bytes_next;
    logic [spr_pkg::LEN_W-1:0]       res_cnt_reg;
    logic [spr_pkg::LEN_W-1:0]       res_cnt_next;
    logic                            res_marker_reg;
    logic                            res_marker_next;
    logic                            res_last_reg;
    logic                            res_last_next;

    spr_pkg::spr_result_t            res;
    logic                            out_xfer;
    logic                            buf_free;
    logic                            fire;
    logic                            produce;

    spr_match u_match
    (
        .item               (in_item_reg),
        .win                (win_reg),
        .pend               (pend_reg),
        .replaced           (repl_reg),
        .pattern_bytes      (pattern_bytes_reg),
        .pattern_length     (pattern_length_reg),
        .replacement_bytes  (replacement_bytes_reg),
        .replacement_length (replacement_length_reg),
        .first_only         (first_only_reg),
        .res                (res)
    );

    // Process the held byte once the buffer empties this cycle; while earlier
    // results are still draining, the next byte waits in the input register.
    assign out_valid = (res_cnt_reg != '0);
    assign out_xfer  = out_valid && out_ready;
    assign buf_free  = (res_cnt_reg == '0) ||
                       (out_xfer && (res_cnt_reg == spr_pkg::LEN_W'(1)));
    assign fire      = in_valid_reg && buf_free;
    assign produce   = fire && (res.cnt != '0);
    assign in_ready  = !in_valid_reg || fire;

    assign out_data.out_byte = res_bytes_reg[0];
    assign out_data.has_byte = !res_marker_reg;
    assign out_data.out_end  = res_last_reg && (res_cnt_reg == spr_pkg::LEN_W'(1));

    always_comb
    begin
        res_bytes_next  = res_bytes_reg;
        res_cnt_next    = res_cnt_reg;
        res_marker_next = res_marker_reg;
        res_last_next   = res_last_reg;
        if (produce)
        begin
            res_bytes_next  = res.bytes;
            res_cnt_next    = res.cnt;
            res_marker_next = res.marker;
            res_last_next   = res.last;
        end
        else if (out_xfer)
        begin
            // advance the buffer by one item
            for (int i = 0; i < spr_pkg::MAX_PATTERN - 1; i++)
            begin
                res_bytes_next[i] = res_bytes_reg[i+1];
            end
            res_bytes_next[spr_pkg::MAX_PATTERN-1] = '0;
            res_cnt_next = res_cnt_reg - spr_pkg::LEN_W'(1);
        end
    end

    always_comb
    begin
        win_next  = win_reg;
        pend_next = pend_reg;
        repl_next = repl_reg;
        if (fire)
        begin
            win_next  = res.win_next;
            pend_next = res.pend_next;
            repl_next = res.repl_next;
        end
        // a shorter pattern that no longer exceeds the pending count drops the window
        if (cfg_we && (cfg_index == spr_pkg::REG_PATTERN_LENGTH) &&
            (spr_pkg::eff_plen(cfg_data[spr_pkg::LEN_W-1:0]) <=
             spr_pkg::LEN_W'(pend_next)))
        begin
            pend_next = '0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= spr_pkg::LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            first_only_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spr_pkg::REG_PATTERN_BYTES:      pattern_bytes_reg <= cfg_data;
                spr_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[spr_pkg::LEN_W-1:0];
                spr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_reg <= cfg_data;
                spr_pkg::REG_REPLACEMENT_LENGTH:
                    replacement_length_reg <= cfg_data[spr_pkg::LEN_W-1:0];
                spr_pkg::REG_FIRST_ONLY:         first_only_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pend_reg       <= '0;
            repl_reg       <= 1'b0;
            res_cnt_reg    <= '0;
            res_marker_reg <= 1'b0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            pend_reg       <= pend_next;
            repl_reg       <= repl_next;
            res_cnt_reg    <= res_cnt_next;
            res_marker_reg <= res_marker_next;
            res_last_reg   <= res_last_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        win_reg       <= win_next;
        res_bytes_reg <= res_bytes_next;
    end

endmodule

>>> rtl/spr_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_match: window compare and result build for one text byte
// Appends the byte to the pending window, compares against the pattern and
// forms the result list and the next window state.
// ----------------------------------------------------------------------------
module spr_match
(
    input  spr_pkg::in_item_t                  item,
    input  spr_pkg::window_t                   win,
    input  logic [spr_pkg::WIN_IDX_W-1:0]      pend,
    input  logic                               replaced,
    input  logic [spr_pkg::CFG_DATA_W-1:0]     pattern_bytes,
    input  logic [spr_pkg::LEN_W-1:0]          pattern_length,
    input  logic [spr_pkg::CFG_DATA_W-1:0]     replacement_bytes,
    input  logic [spr_pkg::LEN_W-1:0]          replacement_length,
    input  logic                               first_only,
    output spr_pkg::spr_result_t               res
);

    spr_pkg::window_t             app;
    logic [spr_pkg::LEN_W-1:0]    plen;
    logic [spr_pkg::LEN_W-1:0]    rlen;
    logic [spr_pkg::LEN_W-1:0]    fill;
    logic                         full;
    logic                         hit;

    always_comb
    begin
        plen = spr_pkg::eff_plen(pattern_length);
        rlen = spr_pkg::eff_rlen(replacement_length);
        fill = spr_pkg::LEN_W'(pend) + spr_pkg::LEN_W'(1);
        full = (fill == plen);

        // append the new byte at the fill position
        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
        begin
            app[i] = (pend == spr_pkg::WIN_IDX_W'(i)) ? item.text_byte : win[i];
        end

        hit = full && !(first_only && replaced);
        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
        begin
            if ((spr_pkg::LEN_W'(i) < plen) && (app[i] != pattern_bytes[8*i +: 8]))
            begin
                hit = 1'b0;
            end
        end

        res = '0;
        res.win_next  = app;
        res.pend_next = pend;
        res.repl_next = replaced;

        if (hit)
        begin
            for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
            begin
                res.bytes[i] = replacement_bytes[8*i +: 8];
            end
            res.cnt       = rlen;
            res.pend_next = '0;
            res.repl_next = 1'b1;
        end
        else if (full)
        begin
            // emit the head byte, slide the window by one
            res.bytes[0] = app[0];
            res.cnt      = spr_pkg::LEN_W'(1);
            for (int i = 0; i < spr_pkg::MAX_PATTERN - 1; i++)
            begin
                res.win_next[i] = app[i+1];
            end
            res.pend_next = spr_pkg::WIN_IDX_W'(plen - spr_pkg::LEN_W'(1));
        end
        else
        begin
            res.pend_next = spr_pkg::WIN_IDX_W'(fill);
        end

        if (item.text_end)
        begin
            // flush: on a miss the result is the whole appended window
            if (!hit)
            begin
                res.bytes = app;
                res.cnt   = fill;
            end
            res.last      = 1'b1;
            res.pend_next = '0;
            res.repl_next = 1'b0;
            if (res.cnt == '0)
            begin
                res.bytes  = '0;
                res.cnt    = spr_pkg::LEN_W'(1);
                res.marker = 1'b1;
            end
        end
    end

endmodule
